FILE: rtl/tfms_pkg.sv
// ----------------------------------------------------------------------------
// tfms_pkg
// Shared types and constants of the timed flap motor sequencer.
// ----------------------------------------------------------------------------
package tfms_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int CMP_W   = 10;
    localparam int SPEED_W = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // flap position codes
    typedef enum logic [1:0] {
        POS_CLOSED  = 2'd0,
        POS_OPENING = 2'd1,
        POS_OPENED  = 2'd2,
        POS_CLOSING = 2'd3
    } pos_t;

    // request mode codes
    localparam logic MODE_OPEN  = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MOTOR_ENABLE    = 2'd0;
    localparam logic [1:0] REG_RUN_TIME_IS_SET = 2'd1;
    localparam logic [1:0] REG_MOTOR_SPEED     = 2'd2;

    // speed handling
    localparam int unsigned SPEED_RESET = 90;
    localparam int unsigned SPEED_FULL  = 100;

    // compare scaling: product / 100 by reciprocal, saturation at 1023
    localparam int unsigned CMP_SAT         = 1023;
    localparam int unsigned CMP_SAT_PRODUCT = 102300;
    localparam int          QUOT_IN_W       = 17;
    localparam int          RECIP_W         = 30;
    localparam int          RECIP_SHIFT     = 19;
    localparam int unsigned RECIP_100       = 5242;

    // request word
    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] now_ms;
        logic              target_open;
        logic              wait_for_button;
        logic              reverse_load;
        logic [TIME_W-1:0] reverse_time_ms;
    } req_t;

    // result word
    typedef struct packed {
        logic [1:0]        flap_position;
        logic              motor_running;
        logic              drive_open;
        logic              drive_close;
        logic              relay_close;
        logic [CMP_W-1:0]  pwm_compare;
        logic              overrun_error;
        logic [TIME_W-1:0] elapsed_ms;
    } res_t;

    // settings handed from the register block to the core
    typedef struct packed {
        logic             motor_enable;
        logic             run_time_is_set;
        logic [CMP_W-1:0] compare;
    } cfg_t;

endpackage

FILE: rtl/tfms_if.sv
// ----------------------------------------------------------------------------
// tfms_req_if / tfms_res_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tfms_req_if import tfms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [TIME_W-1:0] now_ms;
    logic              target_open;
    logic              wait_for_button;
    logic              reverse_load;
    logic [TIME_W-1:0] reverse_time_ms;

    modport source (
        output valid, mode, now_ms, target_open, wait_for_button,
               reverse_load, reverse_time_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, now_ms, target_open, wait_for_button,
               reverse_load, reverse_time_ms,
        output ready
    );
endinterface

interface tfms_res_if import tfms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        flap_position;
    logic              motor_running;
    logic              drive_open;
    logic              drive_close;
    logic              relay_close;
    logic [CMP_W-1:0]  pwm_compare;
    logic              overrun_error;
    logic [TIME_W-1:0] elapsed_ms;

    modport source (
        output valid, flap_position, motor_running, drive_open, drive_close,
               relay_close, pwm_compare, overrun_error, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, flap_position, motor_running, drive_open, drive_close,
               relay_close, pwm_compare, overrun_error, elapsed_ms,
        output ready
    );
endinterface

FILE: rtl/tfms_cfg.sv
// ----------------------------------------------------------------------------
// tfms_cfg
// APB register block; derives the PWM compare value from the speed setting.
// ----------------------------------------------------------------------------
module tfms_cfg
    import tfms_pkg::*;
#(
    parameter int PWM_MAX = 1000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    localparam int PROD_W    = $clog2(PWM_MAX * SPEED_FULL + 1);
    localparam int EXT_W     = (PROD_W > QUOT_IN_W) ? PROD_W : QUOT_IN_W;
    localparam int PROD_RST  = PWM_MAX * SPEED_RESET;

    logic                enable_reg;
    logic                set_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [PROD_W-1:0]   product_reg;
    logic [PROD_W-1:0]   product_next;
    logic [CMP_W-1:0]    cmp_next;
    logic                wr;
    logic [1:0]          reg_idx;
    logic [SPEED_W-1:0]  speed_clamped;

    logic [EXT_W-1:0]     prod_ext;
    logic [QUOT_IN_W-1:0] prod_low;
    logic [RECIP_W-1:0]   recip_mul;
    logic [10:0]          quot_est;
    logic [QUOT_IN_W-1:0] remainder;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // speed above full scale counts as full scale
    assign speed_clamped = (pwdata[SPEED_W-1:0] > SPEED_W'(SPEED_FULL))
                         ? SPEED_W'(SPEED_FULL) : pwdata[SPEED_W-1:0];
    assign product_next  = PROD_W'(PWM_MAX) * PROD_W'(speed_clamped);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            set_reg     <= 1'b1;
            speed_reg   <= SPEED_W'(SPEED_RESET);
            product_reg <= PROD_W'(PROD_RST);
        end
        else
        begin
            if (wr)
            begin
                unique case (reg_idx)
                    REG_MOTOR_ENABLE:    enable_reg <= pwdata[0];
                    REG_RUN_TIME_IS_SET: set_reg    <= pwdata[0];
                    REG_MOTOR_SPEED:
                    begin
                        speed_reg   <= pwdata[SPEED_W-1:0];
                        product_reg <= product_next;
                    end
                    default: ;
                endcase
            end
        end
    end

    // product / 100 by reciprocal multiply with one correction step
    always_comb
    begin
        prod_ext  = EXT_W'(product_reg);
        prod_low  = prod_ext[QUOT_IN_W-1:0];
        recip_mul = RECIP_W'(prod_low) * RECIP_W'(RECIP_100);
        quot_est  = recip_mul[RECIP_W-1:RECIP_SHIFT];
        remainder = prod_low - QUOT_IN_W'(quot_est) * QUOT_IN_W'(SPEED_FULL);
        if (prod_ext >= EXT_W'(CMP_SAT_PRODUCT))
            cmp_next = CMP_W'(CMP_SAT);
        else if (remainder >= QUOT_IN_W'(SPEED_FULL))
            cmp_next = CMP_W'(quot_est + 11'd1);
        else
            cmp_next = CMP_W'(quot_est);
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_MOTOR_ENABLE:    prdata = DATA_W'(enable_reg);
            REG_RUN_TIME_IS_SET: prdata = DATA_W'(set_reg);
            REG_MOTOR_SPEED:     prdata = DATA_W'(speed_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.motor_enable    = enable_reg;
    assign cfg.run_time_is_set = set_reg;
    assign cfg.compare         = cmp_next;

endmodule

FILE: rtl/tfms_core.sv
// ----------------------------------------------------------------------------
// tfms_core
// Flap and motor state with the combinational update for one request word.
// ----------------------------------------------------------------------------
module tfms_core
    import tfms_pkg::*;
#(
    parameter int TIMEOUT_MS        = 60000,
    parameter int DEFAULT_RUN_MS    = 10000,
    parameter int OVERRUN_MARGIN_MS = 3000
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t item,
    input  cfg_t cfg,
    output res_t res
);

    pos_t              pos_reg,      pos_next;
    logic              running_reg,  running_next;
    logic [TIME_W-1:0] start_reg,    start_next;
    logic [TIME_W-1:0] rtl_reg,      rtl_next;
    logic [TIME_W-1:0] rev_reg,      rev_next;
    logic              en_open_reg,  en_open_next;
    logic              en_close_reg, en_close_next;
    logic              relay_reg,    relay_next;
    logic [CMP_W-1:0]  cmp_reg,      cmp_next;
    logic              err_reg,      err_next;
    logic [TIME_W-1:0] el_reg,       el_next;

    pos_t              dir;
    logic              allowed;
    logic              move;
    logic [TIME_W-1:0] rev_eff;
    logic [TIME_W-1:0] start_cur;
    logic              relay_cur;
    logic [TIME_W-1:0] el;
    logic              over;
    logic              halt;

    // next state for one request
    always_comb
    begin
        rev_eff = item.reverse_load ? item.reverse_time_ms : rev_reg;
        if (item.mode == MODE_OPEN)
        begin
            dir     = POS_OPENING;
            allowed = (pos_reg != POS_OPENED) && item.target_open;
        end
        else
        begin
            dir     = POS_CLOSING;
            allowed = (pos_reg != POS_CLOSED) && !item.target_open;
        end
        move      = cfg.motor_enable && allowed && !item.wait_for_button;
        start_cur = running_reg ? start_reg : item.now_ms;
        relay_cur = running_reg ? relay_reg : (dir == POS_CLOSING);
        el        = item.now_ms - start_cur;
        over      = ({1'b0, el} >= (TIME_W+1)'(TIMEOUT_MS))
                 || (cfg.run_time_is_set
                     && ({1'b0, el} >= {1'b0, rtl_reg} + (TIME_W+1)'(OVERRUN_MARGIN_MS)));
        halt      = (rev_eff != '0) ? (el >= rev_eff)
                                    : (cfg.run_time_is_set && (el >= rtl_reg));

        pos_next      = pos_reg;
        running_next  = running_reg;
        start_next    = start_reg;
        rtl_next      = rtl_reg;
        rev_next      = rev_eff;
        en_open_next  = en_open_reg;
        en_close_next = en_close_reg;
        relay_next    = relay_reg;
        cmp_next      = cmp_reg;
        err_next      = err_reg;
        el_next       = el_reg;

        if (move)
        begin
            start_next = start_cur;
            el_next    = el;
            err_next   = err_reg || over;
            if (!cfg.run_time_is_set)
                rtl_next = el;
            if (halt)
            begin
                // motor stops; with a known run time the move counts as done
                running_next  = 1'b0;
                en_open_next  = 1'b0;
                en_close_next = 1'b0;
                relay_next    = 1'b0;
                cmp_next      = '0;
                if (cfg.run_time_is_set)
                    pos_next = (dir == POS_OPENING) ? POS_OPENED : POS_CLOSED;
                else
                    pos_next = dir;
                if (rev_eff != '0)
                    rev_next = '0;
            end
            else
            begin
                pos_next      = dir;
                running_next  = 1'b1;
                en_open_next  = en_open_reg  || (dir == POS_OPENING);
                en_close_next = en_close_reg || (dir == POS_CLOSING);
                relay_next    = relay_cur;
                cmp_next      = cfg.compare;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_CLOSED;
            running_reg  <= 1'b0;
            start_reg    <= '0;
            rtl_reg      <= TIME_W'(DEFAULT_RUN_MS);
            rev_reg      <= '0;
            en_open_reg  <= 1'b0;
            en_close_reg <= 1'b0;
            relay_reg    <= 1'b0;
            cmp_reg      <= '0;
            err_reg      <= 1'b0;
            el_reg       <= '0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            running_reg  <= running_next;
            start_reg    <= start_next;
            rtl_reg      <= rtl_next;
            rev_reg      <= rev_next;
            en_open_reg  <= en_open_next;
            en_close_reg <= en_close_next;
            relay_reg    <= relay_next;
            cmp_reg      <= cmp_next;
            err_reg      <= err_next;
            el_reg       <= el_next;
        end
    end

    // result word shows the state after the request
    always_comb
    begin
        res.flap_position = pos_next;
        res.motor_running = running_next;
        res.drive_open    = en_open_next;
        res.drive_close   = en_close_next;
        res.relay_close   = relay_next;
        res.pwm_compare   = cmp_next;
        res.overrun_error = err_next;
        res.elapsed_ms    = el_next;
    end

    // stopped motor leaves every drive output off
    a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (!en_open_reg && !en_close_reg && !relay_reg && cmp_reg == '0))
        else $error("drive output active while motor stopped");

    // running motor has a direction enabled
    a_running_dir: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (en_open_reg || en_close_reg))
        else $error("motor running with no direction enable");

    // state moves only on a request
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(pos_reg) && $stable(running_reg) && $stable(rtl_reg)))
        else $error("state changed without a request");

endmodule

FILE: rtl/timed_flap_motor_sequencer.sv
// ----------------------------------------------------------------------------
// timed_flap_motor_sequencer
// Flap motor sequencer: open/close requests in, drive and status words out.
// ----------------------------------------------------------------------------
// Usage
//   req: valid/ready channel of request words (mode, timestamp, target,
//        wait-for-button, reverse-time load). res: valid/ready channel with
//        one status word per request, showing the state after that request.
//   APB port: motor_enable at 0x0, run_time_is_set at 0x4,
//        motor_speed_percent at 0x8; write only while no request is in flight.
//        A register write applies to every word processed after that edge.
// Pipeline
//   An accepted word sits in the input register; when it advances, its result
//   is loaded into the output register, which drives res.valid. One word per
//   cycle is sustained unless res.ready stalls; the whole state update is one
//   subtract-and-compare stage between the input register and the result
//   register, and the next word sees the updated state.
// Reset
//   rst_n clears the flap to closed, motor off, run time to DEFAULT_RUN_MS,
//   registers to enable=1, run time set=1, speed=90.
// Stall
//   While res.ready is low the result holds; one more word is taken into the
//   input register, then req.ready drops until the result leaves.
// ----------------------------------------------------------------------------
module timed_flap_motor_sequencer
    import tfms_pkg::*;
#(
    parameter int PWM_MAX           = 1000,
    parameter int TIMEOUT_MS        = 60000,
    parameter int DEFAULT_RUN_MS    = 10000,
    parameter int OVERRUN_MARGIN_MS = 3000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    tfms_req_if.sink          req,
    tfms_res_if.source        res
);

    cfg_t cfg;
    req_t in_word;
    res_t core_res;

    logic s1_valid_reg,  s1_valid_next;
    req_t s1_item_reg;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;
    logic in_take;
    logic advance;

    // register block
    tfms_cfg #(
        .PWM_MAX (PWM_MAX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: input register feeds output register
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    always_comb
    begin
        in_word.mode            = req.mode;
        in_word.now_ms          = req.now_ms;
        in_word.target_open     = req.target_open;
        in_word.wait_for_button = req.wait_for_button;
        in_word.reverse_load    = req.reverse_load;
        in_word.reverse_time_ms = req.reverse_time_ms;

        s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_word;
        if (advance)
            out_res_reg <= core_res;
    end

    // state update
    tfms_core #(
        .TIMEOUT_MS        (TIMEOUT_MS),
        .DEFAULT_RUN_MS    (DEFAULT_RUN_MS),
        .OVERRUN_MARGIN_MS (OVERRUN_MARGIN_MS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (s1_item_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // result channel
    assign res.valid         = out_valid_reg;
    assign res.flap_position = out_res_reg.flap_position;
    assign res.motor_running = out_res_reg.motor_running;
    assign res.drive_open    = out_res_reg.drive_open;
    assign res.drive_close   = out_res_reg.drive_close;
    assign res.relay_close   = out_res_reg.relay_close;
    assign res.pwm_compare   = out_res_reg.pwm_compare;
    assign res.overrun_error = out_res_reg.overrun_error;
    assign res.elapsed_ms    = out_res_reg.elapsed_ms;

    // an accepted word is held in the input register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted word not captured");

    // a waiting word is neither lost nor changed
    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("waiting word dropped or altered");

    // every processed word produces a result
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word produced no result");

endmodule
